### rtl/iiz_pkg.sv
// Shared types, constants and lookup tables for the integer image zoom block.
// Depends on nothing; imported by rtl/integer_image_zoom.sv and the testbench files.

package iiz_pkg;

  // Field widths fixed by the pixel and result formats
  localparam int PIX_W     = 8;
  localparam int COORD_W   = 13;
  localparam int SUM_W     = 14;
  localparam int ROW_W     = 10;
  localparam int ROW_LIMIT = 1024;
  localparam int CFG_W     = 11;
  localparam int IDX_W     = 2;
  localparam int FACT_W    = 5;
  localparam int CHAN_W    = 2;
  localparam int RECIP_SH  = 16;
  localparam int RECIP_W   = 16;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_WIDTH    = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_FACTOR   = 2'd2;
  localparam logic [IDX_W-1:0] REG_CHANNELS = 2'd3;

  // color_channels value that selects RGB
  localparam logic [CHAN_W-1:0] RGB_CODE = 2'd3;

  // Scaling modes
  localparam logic [1:0] MODE_COPY   = 2'd0;
  localparam logic [1:0] MODE_GROW   = 2'd1;
  localparam logic [1:0] MODE_SHRINK = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [SUM_W-1:0] sum_t;

  // floor(2^16 / a) for block edge a
  function automatic logic [RECIP_W-1:0] recip_factor(logic [3:0] a);
    logic [RECIP_W-1:0] r;
    case (a)
      4'd2:    r = 16'd32768;
      4'd3:    r = 16'd21845;
      4'd4:    r = 16'd16384;
      4'd5:    r = 16'd13107;
      4'd6:    r = 16'd10922;
      4'd7:    r = 16'd9362;
      4'd8:    r = 16'd8192;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  // floor(2^16 / (a*a)) for block area
  function automatic logic [RECIP_W-1:0] recip_area(logic [3:0] a);
    logic [RECIP_W-1:0] r;
    case (a)
      4'd2:    r = 16'd16384;
      4'd3:    r = 16'd7281;
      4'd4:    r = 16'd4096;
      4'd5:    r = 16'd2621;
      4'd6:    r = 16'd1820;
      4'd7:    r = 16'd1337;
      4'd8:    r = 16'd1024;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/integer_image_zoom.sv
// Integer image zoom: replicate to enlarge, box average to shrink.
// Depends on rtl/iiz_pkg.sv.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes image_width,
//   image_height, zoom_factor and color_channels; always ready, write only
//   while no pixel is in flight.
//   pixel channel (pixel_valid/pixel_ready, red/green/blue) takes raster
//   pixels; result channel (result_valid/result_ready) returns output pixels
//   with their output coordinates and last_of_run on the final one.
// Sequencing, one pixel in flight at a time:
//   copy: setup, then one result.
//   enlarge by a: setup, then a*a results, one result per cycle from the
//   replication counter while the receiver takes them.
//   shrink by a: setup, reciprocal divide and block check; a dropped edge pixel
//   ends there, one that adds to a block goes on through the line store
//   read-modify-write, and one that closes it also through the two-step average divide.
//   A pixel's read and write finish before the next pixel, so they never overlap.
// A result sits in the output register until taken; a stalled receiver
// holds the sequencer at its next result. Reset returns the registers to
// 1024x1024, factor 1, RGB and the position to (0,0); the line store is not
// cleared (every block's first pixel overwrites its entry).

module integer_image_zoom #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_FACTOR = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [iiz_pkg::IDX_W-1:0]   cfg_index,
  input  logic [iiz_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        pixel_valid,
  output logic                        pixel_ready,
  input  logic [iiz_pkg::PIX_W-1:0]   red,
  input  logic [iiz_pkg::PIX_W-1:0]   green,
  input  logic [iiz_pkg::PIX_W-1:0]   blue,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [iiz_pkg::PIX_W-1:0]   out_red,
  output logic [iiz_pkg::PIX_W-1:0]   out_green,
  output logic [iiz_pkg::PIX_W-1:0]   out_blue,
  output logic [iiz_pkg::COORD_W-1:0] out_row,
  output logic [iiz_pkg::COORD_W-1:0] out_col,
  output logic                        last_of_run
);
  import iiz_pkg::*;

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW         = $clog2(LINE_DEPTH);
  localparam int XW         = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int FW         = $clog2(MAX_FACTOR + 1);
  localparam int PCW        = CW + RECIP_SH;
  localparam int PRW        = ROW_W + RECIP_SH;
  localparam int PSW        = SUM_W + RECIP_W;
  localparam int HW         = ROW_W + 1;

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SETUP  = 4'd1;
  localparam logic [3:0] S_EMIT   = 4'd2;
  localparam logic [3:0] S_REP    = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_CHK    = 4'd5;
  localparam logic [3:0] S_ACC    = 4'd6;
  localparam logic [3:0] S_AVG1   = 4'd7;
  localparam logic [3:0] S_AVG2   = 4'd8;
  localparam logic [3:0] S_AVGOUT = 4'd9;

  // Configuration registers
  logic [CFG_W-1:0]         image_width;
  logic [CFG_W-1:0]         image_height;
  logic signed [FACT_W-1:0] zoom_factor;
  logic [CHAN_W-1:0]        color_channels;

  // Position and sequencer
  logic [3:0]       state;
  logic [CW-1:0]    column_count;
  logic [ROW_W-1:0] row_count;
  logic [CW-1:0]    pos_col;
  logic [ROW_W-1:0] pos_row;
  logic [1:0]       mode;
  logic [FW-1:0]    factor_mag;
  pix_t             pix_r, pix_g, pix_b;

  // Enlarge counters
  logic [COORD_W-1:0] grow_row, grow_col, grow_col_base;
  logic [FW-1:0]      rep_k, rep_l;

  // Shrink datapath
  logic [PCW-1:0]   prod_col;
  logic [PRW-1:0]   prod_row;
  logic [CW-1:0]    qcol;
  logic [ROW_W-1:0] qrow;
  logic [FW-1:0]    rcol, rrow;
  logic [3*SUM_W-1:0] line_mem [LINE_DEPTH];
  logic [3*SUM_W-1:0] rd_data;
  sum_t             sums [3];
  logic [PSW-1:0]   prod_sum [3];
  pix_t             avg [3];

  // Effective (clamped) settings
  logic [XW-1:0]            w_eff;
  logic [HW-1:0]            h_eff;
  logic signed [FACT_W-1:0] f_clamp;
  logic [1:0]               mode_next;
  logic [FW-1:0]            mag_next;
  logic                     gray;

  always_comb begin
    w_eff = XW'(image_width);
    if (image_width == '0) begin
      w_eff = XW'(1);
    end else if (w_eff > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end
    h_eff = HW'(image_height);
    if (image_height == '0) begin
      h_eff = HW'(1);
    end else if (image_height > CFG_W'(ROW_LIMIT)) begin
      h_eff = HW'(ROW_LIMIT);
    end
  end

  always_comb begin
    f_clamp = zoom_factor;
    if (zoom_factor > $signed(FACT_W'(MAX_FACTOR))) begin
      f_clamp = $signed(FACT_W'(MAX_FACTOR));
    end else if (zoom_factor < -$signed(FACT_W'(MAX_FACTOR))) begin
      f_clamp = -$signed(FACT_W'(MAX_FACTOR));
    end
    if (f_clamp > $signed(FACT_W'(1))) begin
      mode_next = MODE_GROW;
      mag_next  = FW'(f_clamp);
    end else if (f_clamp < -$signed(FACT_W'(1))) begin
      mode_next = MODE_SHRINK;
      mag_next  = FW'(-f_clamp);
    end else begin
      mode_next = MODE_COPY;
      mag_next  = FW'(1);
    end
  end

  assign gray = (color_channels != RGB_CODE);

  // Start-of-pixel position, wrapped against the current size
  logic             col_wrap;
  logic [HW-1:0]    row_t;
  logic [CW-1:0]    col_n;
  logic [ROW_W-1:0] row_n;

  always_comb begin
    col_wrap = (XW'(column_count) >= w_eff);
    row_t    = HW'(row_count) + HW'(col_wrap);
    col_n    = col_wrap ? '0 : column_count;
    row_n    = (row_t >= h_eff) ? '0 : row_t[ROW_W-1:0];
  end

  // Position after this pixel
  logic [XW-1:0] col_p;
  logic [HW-1:0] row_p;

  always_comb begin
    col_p = XW'(pos_col) + XW'(1);
    row_p = HW'(pos_row) + HW'(1);
  end

  // Reciprocal divide correction: one compare and subtract
  logic [CW-1:0]    qc_est;
  logic [ROW_W-1:0] qr_est;
  logic [CW:0]      rc_raw;
  logic [HW-1:0]    rr_raw;
  logic             rc_over, rr_over;

  always_comb begin
    qc_est  = prod_col[PCW-1:RECIP_SH];
    qr_est  = prod_row[PRW-1:RECIP_SH];
    rc_raw  = (CW+1)'(pos_col) - (CW+1)'(qc_est) * (CW+1)'(factor_mag);
    rr_raw  = HW'(pos_row) - HW'(qr_est) * HW'(factor_mag);
    rc_over = (rc_raw >= (CW+1)'(factor_mag));
    rr_over = (rr_raw >= HW'(factor_mag));
  end

  // Block membership: full blocks only, partial edge blocks dropped
  logic in_block;

  always_comb begin
    in_block = ((XW'(pos_col) - XW'(rcol) + XW'(factor_mag)) <= w_eff) &&
               ((HW'(pos_row) - HW'(rrow) + HW'(factor_mag)) <= h_eff) &&
               (qcol < CW'(LINE_DEPTH));
  end

  // Sum update for the read-modify-write
  logic                  block_first, block_last;
  sum_t                  sum_next [3];
  logic [3*SUM_W-1:0]    wr_data;
  pix_t                  pix_ch [3];

  always_comb begin
    block_first = (rcol == '0) && (rrow == '0);
    block_last  = (rcol == factor_mag - FW'(1)) && (rrow == factor_mag - FW'(1));
    pix_ch[0]   = pix_r;
    pix_ch[1]   = pix_g;
    pix_ch[2]   = pix_b;
    for (int c = 0; c < 3; c++) begin
      sum_next[c] = block_first ? SUM_W'(pix_ch[c])
                                : rd_data[c*SUM_W +: SUM_W] + SUM_W'(pix_ch[c]);
    end
    wr_data = {sum_next[2], sum_next[1], sum_next[0]};
  end

  // Average: reciprocal estimate, correction, saturation
  logic [SUM_W-1:0] area;
  sum_t             q_est [3];
  sum_t             q_fix [3];
  sum_t             rem [3];
  pix_t             avg_next [3];

  always_comb begin
    area = SUM_W'(factor_mag) * SUM_W'(factor_mag);
    for (int c = 0; c < 3; c++) begin
      q_est[c] = prod_sum[c][PSW-1:RECIP_SH];
      rem[c]   = sums[c] - q_est[c] * area;
      q_fix[c] = (rem[c] >= area) ? q_est[c] + SUM_W'(1) : q_est[c];
      avg_next[c] = (q_fix[c] > SUM_W'(255)) ? 8'hFF : q_fix[c][PIX_W-1:0];
    end
  end

  // Handshakes
  logic out_free, pix_accept, load_out;

  assign cfg_ready   = 1'b1;
  assign pixel_ready = (state == S_IDLE);
  assign pix_accept  = pixel_valid && pixel_ready;
  assign out_free    = !result_valid || result_ready;
  assign load_out    = out_free &&
                       (state == S_EMIT || state == S_REP || state == S_AVGOUT);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= CFG_W'(1024);
      image_height   <= CFG_W'(1024);
      zoom_factor    <= FACT_W'(1);
      color_channels <= RGB_CODE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:    image_width    <= cfg_data;
        REG_HEIGHT:   image_height   <= cfg_data;
        REG_FACTOR:   zoom_factor    <= $signed(cfg_data[FACT_W-1:0]);
        REG_CHANNELS: color_channels <= cfg_data[CHAN_W-1:0];
        default:      ;
      endcase
    end
  end

  // Sequencer and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pix_accept) state <= S_SETUP;
        end
        S_SETUP: begin
          if (col_p >= w_eff) begin
            column_count <= '0;
            row_count    <= (row_p >= h_eff) ? '0 : row_p[ROW_W-1:0];
          end else begin
            column_count <= col_p[CW-1:0];
            row_count    <= pos_row;
          end
          if (mode == MODE_GROW) begin
            state <= S_REP;
          end else if (mode == MODE_SHRINK) begin
            state <= S_DIV;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) state <= S_IDLE;
        end
        S_REP: begin
          if (out_free && rep_k == factor_mag - FW'(1) &&
              rep_l == factor_mag - FW'(1)) begin
            state <= S_IDLE;
          end
        end
        S_DIV:  state <= S_CHK;
        S_CHK:  state <= in_block ? S_ACC : S_IDLE;
        S_ACC:  state <= block_last ? S_AVG1 : S_IDLE;
        S_AVG1: state <= S_AVG2;
        S_AVG2: state <= S_AVGOUT;
        S_AVGOUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Pixel capture and setup arithmetic
  always_ff @(posedge clk) begin
    if (pix_accept) begin
      pos_col    <= col_n;
      pos_row    <= row_n;
      mode       <= mode_next;
      factor_mag <= mag_next;
      pix_r      <= red;
      pix_g      <= gray ? red : green;
      pix_b      <= gray ? red : blue;
    end
    if (state == S_SETUP) begin
      grow_row      <= COORD_W'(pos_row) * COORD_W'(factor_mag);
      grow_col      <= COORD_W'(pos_col) * COORD_W'(factor_mag);
      grow_col_base <= COORD_W'(pos_col) * COORD_W'(factor_mag);
      rep_k         <= '0;
      rep_l         <= '0;
      prod_col      <= PCW'(pos_col) * PCW'(recip_factor(4'(factor_mag)));
      prod_row      <= PRW'(pos_row) * PRW'(recip_factor(4'(factor_mag)));
    end
    // Replication walk: column offset inner, row offset outer
    if (state == S_REP && out_free) begin
      if (rep_l == factor_mag - FW'(1)) begin
        rep_l    <= '0;
        rep_k    <= rep_k + FW'(1);
        grow_col <= grow_col_base;
        grow_row <= grow_row + COORD_W'(1);
      end else begin
        rep_l    <= rep_l + FW'(1);
        grow_col <= grow_col + COORD_W'(1);
      end
    end
    if (state == S_DIV) begin
      qcol <= rc_over ? qc_est + CW'(1) : qc_est;
      rcol <= rc_over ? FW'(rc_raw - (CW+1)'(factor_mag)) : FW'(rc_raw);
      qrow <= rr_over ? qr_est + ROW_W'(1) : qr_est;
      rrow <= rr_over ? FW'(rr_raw - HW'(factor_mag)) : FW'(rr_raw);
    end
    if (state == S_ACC) begin
      for (int c = 0; c < 3; c++) sums[c] <= sum_next[c];
    end
    if (state == S_AVG1) begin
      for (int c = 0; c < 3; c++) begin
        prod_sum[c] <= PSW'(sums[c]) * PSW'(recip_area(4'(factor_mag)));
      end
    end
    if (state == S_AVG2) begin
      for (int c = 0; c < 3; c++) avg[c] <= avg_next[c];
    end
  end

  // Line store of per-block channel sums
  always_ff @(posedge clk) begin
    if (state == S_CHK && in_block) begin
      rd_data <= line_mem[qcol[AW-1:0]];
    end
    if (state == S_ACC) begin
      line_mem[qcol[AW-1:0]] <= wr_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      unique case (state)
        S_EMIT: begin
          out_red     <= pix_r;
          out_green   <= pix_g;
          out_blue    <= pix_b;
          out_row     <= COORD_W'(pos_row);
          out_col     <= COORD_W'(pos_col);
          last_of_run <= 1'b1;
        end
        S_REP: begin
          out_red     <= pix_r;
          out_green   <= pix_g;
          out_blue    <= pix_b;
          out_row     <= grow_row;
          out_col     <= grow_col;
          last_of_run <= (rep_k == factor_mag - FW'(1)) &&
                         (rep_l == factor_mag - FW'(1));
        end
        default: begin
          out_red     <= avg[0];
          out_green   <= avg[1];
          out_blue    <= avg[2];
          out_row     <= COORD_W'(qrow);
          out_col     <= COORD_W'(qcol);
          last_of_run <= 1'b1;
        end
      endcase
    end
  end

  // Checks
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SETUP && !cfg_valid) |=> (XW'(column_count) < w_eff))
    else $error("column counter beyond image width");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> (rcol < factor_mag && rrow < factor_mag))
    else $error("block remainder not below factor");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) != S_IDLE))
    else $error("result loaded with no pixel in flight");

endmodule

### tb/zoom_result_checker.sv
// Result checker for the integer image zoom block: watches the config, pixel and
// result channels, predicts every output pixel and compares it field by field.
// Depends on rtl/iiz_pkg.sv; instantiated by tb/tb_integer_image_zoom.sv.

module zoom_result_checker
  import iiz_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               pixel_valid,
  input  logic               pixel_ready,
  input  pix_t               red,
  input  pix_t               green,
  input  pix_t               blue,
  input  logic               result_valid,
  input  logic               result_ready,
  input  pix_t               out_red,
  input  pix_t               out_green,
  input  pix_t               out_blue,
  input  logic [COORD_W-1:0] out_row,
  input  logic [COORD_W-1:0] out_col,
  input  logic               last_of_run,
  output int                 pending,
  output int                 errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_COLS     = 1024;
  localparam int          MAX_ZOOM     = 8;
  localparam int unsigned LINE_ENTRIES = MAX_COLS / 2;

  typedef struct {
    pix_t               red;
    pix_t               green;
    pix_t               blue;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } zoom_px_t;

  // Register copies, as written
  logic [CFG_W-1:0]         width_reg;
  logic [CFG_W-1:0]         height_reg;
  logic signed [FACT_W-1:0] factor_reg;
  logic [CHAN_W-1:0]        channels_reg;

  // Position of the next input pixel and the per-block channel sums
  int unsigned col_pos;
  int unsigned row_pos;
  sum_t        block_sums [LINE_ENTRIES][3];

  zoom_px_t expected_pixels [$];
  zoom_px_t oldest;
  int       fail_total = 0;

  // A finished row or frame (or a shrunken size) wraps the position
  function automatic void wrap_position(int unsigned w, int unsigned h);
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
  endfunction

  function automatic void expect_pixel(pix_t r, pix_t g, pix_t b, int unsigned row,
                                       int unsigned col, logic last);
    zoom_px_t px;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    px.row   = COORD_W'(row);
    px.col   = COORD_W'(col);
    px.last  = last;
    expected_pixels.push_back(px);
  endfunction

  // Output pixels caused by one input pixel
  task automatic predict_zoom(input pix_t r_in, input pix_t g_in, input pix_t b_in);
    int unsigned w;
    int unsigned h;
    int unsigned a;
    int unsigned idx;
    int unsigned avg;
    int          f;
    logic [1:0]  mode;
    pix_t        px [3];
    pix_t        mean [3];

    w = width_reg;
    h = height_reg;
    f = factor_reg;
    if (w < 1) w = 1;
    if (w > MAX_COLS) w = MAX_COLS;
    if (h < 1) h = 1;
    if (h > ROW_LIMIT) h = ROW_LIMIT;
    if (f > MAX_ZOOM) f = MAX_ZOOM;
    if (f < -MAX_ZOOM) f = -MAX_ZOOM;
    mode = (f > 1) ? MODE_GROW : ((f < -1) ? MODE_SHRINK : MODE_COPY);

    wrap_position(w, h);

    // gray mode copies red to all three channels
    px[0] = r_in;
    px[1] = (channels_reg == RGB_CODE) ? g_in : r_in;
    px[2] = (channels_reg == RGB_CODE) ? b_in : r_in;

    case (mode)
      MODE_COPY: begin
        expect_pixel(px[0], px[1], px[2], row_pos, col_pos, 1'b1);
      end
      MODE_GROW: begin
        a = f;
        // replica block: row offset outer, column offset inner
        for (int unsigned k = 0; k < a; k++) begin
          for (int unsigned l = 0; l < a; l++) begin
            expect_pixel(px[0], px[1], px[2], row_pos * a + k, col_pos * a + l,
                         (k == a - 1) && (l == a - 1));
          end
        end
      end
      MODE_SHRINK: begin
        a = -f;
        idx = col_pos / a;
        // partial blocks at the right and bottom edge are dropped
        if (col_pos < (w / a) * a && row_pos < (h / a) * a && idx < LINE_ENTRIES) begin
          for (int c = 0; c < 3; c++) begin
            if (row_pos % a == 0 && col_pos % a == 0) begin
              block_sums[idx][c] = sum_t'(px[c]);
            end else begin
              block_sums[idx][c] = block_sums[idx][c] + px[c];
            end
          end
          // bottom-right pixel closes the block
          if (row_pos % a == a - 1 && col_pos % a == a - 1) begin
            for (int c = 0; c < 3; c++) begin
              avg = block_sums[idx][c] / (a * a);
              if (avg > 255) avg = 255;
              mean[c] = pix_t'(avg);
            end
            expect_pixel(mean[0], mean[1], mean[2], row_pos / a, idx, 1'b1);
          end
        end
      end
      default: ;
    endcase

    col_pos++;
    wrap_position(w, h);
  endtask

  function automatic void check_field(string name, int unsigned want, logic [COORD_W-1:0] got);
    if (got !== COORD_W'(want)) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_total++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg    = CFG_W'(1024);
      height_reg   = CFG_W'(1024);
      factor_reg   = FACT_W'(1);
      channels_reg = RGB_CODE;
      col_pos      = 0;
      row_pos      = 0;
      expected_pixels.delete();
    end else begin
      // compare the result taken at this edge with the oldest prediction
      if (result_valid && result_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result at row %0d col %0d: no request waiting", out_row, out_col);
          fail_total++;
        end else begin
          oldest = expected_pixels.pop_front();
          check_field("out_red", oldest.red, out_red);
          check_field("out_green", oldest.green, out_green);
          check_field("out_blue", oldest.blue, out_blue);
          check_field("out_row", oldest.row, out_row);
          check_field("out_col", oldest.col, out_col);
          check_field("last_of_run", oldest.last, last_of_run);
        end
      end

      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIDTH:    width_reg = cfg_data;
          REG_HEIGHT:   height_reg = cfg_data;
          REG_FACTOR:   factor_reg = cfg_data[FACT_W-1:0];
          REG_CHANNELS: channels_reg = cfg_data[CHAN_W-1:0];
          default: ;
        endcase
      end

      if (pixel_valid && pixel_ready) predict_zoom(red, green, blue);
    end
    pending <= expected_pixels.size();
    errors  <= fail_total;
  end

endmodule

### tb/tb_integer_image_zoom.sv
// Testbench top for integer_image_zoom: clock, reset, pixel and register stimulus,
// receiver back-pressure and the verdict. Depends on rtl/iiz_pkg.sv, the block
// under test and tb/zoom_result_checker.sv.

module tb_integer_image_zoom;
  timeunit 1ns;
  timeprecision 1ps;
  import iiz_pkg::*;

  localparam longint CYCLE_LIMIT        = 4_000_000;
  localparam int     RANDOM_ITEMS       = 420;
  localparam int     MIN_SHRINK_RESULTS = 36;
  localparam int     MAX_GAP            = 18;
  localparam int     HOLD_CYCLES        = 400;
  localparam int     SETTLE_CYCLES      = 12;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               pixel_valid;
  logic               pixel_ready;
  pix_t               red;
  pix_t               green;
  pix_t               blue;
  logic               result_valid;
  logic               result_ready;
  pix_t               out_red;
  pix_t               out_green;
  pix_t               out_blue;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               last_of_run;
  int                 pending;
  int                 errors;

  // Stimulus, receiver and cycle limit state; hold_req is shared by stimulus and receiver
  bit     hold_req;
  bit     send_idle_en;
  bit     pix_on;
  int     items_sent;
  longint cycles;

  integer_image_zoom i_dut (.*);

  zoom_result_checker i_checker (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random stalls per result, one long hold-off on request
  initial begin
    int gap;
    int served;
    bit recv_idle_en;
    served = 0;
    recv_idle_en = 1'b1;
    result_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (served % 50 == 0) recv_idle_en = ($urandom_range(0, 3) != 0);
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = recv_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
      served++;
    end
  end

  function automatic pix_t rand_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Register word with random bits above the field
  function automatic logic [CFG_W-1:0] pad_word(int low_bits, int nbits);
    logic [CFG_W-1:0] word;
    logic [CFG_W-1:0] mask;
    word = CFG_W'($urandom_range(0, 2047));
    mask = CFG_W'((1 << nbits) - 1);
    return (word & ~mask) | (CFG_W'(low_bits) & mask);
  endfunction

  task automatic idle_pixel_port();
    if (pix_on) pixel_valid <= 1'b0;
    pix_on = 1'b0;
  endtask

  // Stop offering pixels and wait until every predicted result has come back
  task automatic drain_results();
    idle_pixel_port();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    drain_results();
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(pix_t r, pix_t g, pix_t b);
    int gap;
    gap = send_idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      idle_pixel_port();
      repeat (gap) @(posedge clk);
    end
    red         <= r;
    green       <= g;
    blue        <= b;
    pixel_valid <= 1'b1;
    pix_on = 1'b1;
    do @(posedge clk); while (!(pixel_valid && pixel_ready));
    items_sent++;
  endtask

  // Force the position back to (0,0): a 1x1 copy frame wraps on every pixel
  task automatic realign_frame();
    write_reg(REG_FACTOR, pad_word(1, FACT_W));
    write_reg(REG_WIDTH, CFG_W'(1));
    write_reg(REG_HEIGHT, CFG_W'(1));
    send_pixel(rand_sample(), rand_sample(), rand_sample());
  endtask

  // Stimulus
  initial begin
    int   f;
    int   a;
    int   w;
    int   h;
    int   n;
    int   frames;
    int   mid;
    int   sel;
    int   shrink_blocks;
    bit   cut_short;
    pix_t v;

    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_WIDTH;
    cfg_data    <= '0;
    pixel_valid <= 1'b0;
    red         <= '0;
    green       <= '0;
    blue        <= '0;
    hold_req     = 1'b0;
    send_idle_en = 1'b1;
    pix_on       = 1'b0;
    items_sent   = 0;
    shrink_blocks = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Copy at reset settings, sample extremes
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h5A, 8'hA5, 8'h0F);

    // Gray mode: red goes to all outputs
    write_reg(REG_CHANNELS, pad_word(1, CHAN_W));
    send_pixel(8'hF0, 8'h12, 8'h34);
    write_reg(REG_CHANNELS, pad_word(RGB_CODE, CHAN_W));

    // Factors 0 and -1 copy as well
    write_reg(REG_FACTOR, pad_word(0, FACT_W));
    send_pixel(rand_sample(), rand_sample(), rand_sample());
    write_reg(REG_FACTOR, pad_word(-1, FACT_W));
    send_pixel(rand_sample(), rand_sample(), rand_sample());

    // Enlarge by 2 with a long receiver hold-off so the block backs up
    write_reg(REG_FACTOR, pad_word(2, FACT_W));
    hold_req = 1'b1;
    repeat (4) send_pixel(rand_sample(), rand_sample(), rand_sample());
    drain_results();

    // Factor above the limit saturates to 8
    write_reg(REG_FACTOR, pad_word(15, FACT_W));
    send_pixel(rand_sample(), rand_sample(), rand_sample());

    // Shrink by 2 over a 4x2 frame: one saturated block, one truncating block
    realign_frame();
    write_reg(REG_WIDTH, CFG_W'(4));
    write_reg(REG_HEIGHT, CFG_W'(2));
    write_reg(REG_CHANNELS, pad_word(RGB_CODE, CHAN_W));
    write_reg(REG_FACTOR, pad_word(-2, FACT_W));
    for (int i = 0; i < 8; i++) begin
      v = (i % 4 < 2) ? 8'hFF : pix_t'((i / 4) * 2 + (i % 4) - 2);
      send_pixel(v, 8'hFF - v, v);
    end

    // Factor below the limit saturates to -8: frame too small, nothing comes out
    write_reg(REG_FACTOR, pad_word(-16, FACT_W));
    repeat (2) send_pixel(rand_sample(), rand_sample(), rand_sample());

    // Random phases until enough pixels and enough averaged blocks
    while (items_sent < RANDOM_ITEMS || shrink_blocks < MIN_SHRINK_RESULTS) begin
      send_idle_en = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 1) == 1) begin
        // Shrink: frames from (0,0), sometimes cut short, small blocks preferred
        sel = $urandom_range(0, 9);
        a = (sel < 6) ? $urandom_range(2, 3) : ((sel < 9) ? $urandom_range(4, 5)
                                                           : $urandom_range(6, 8));
        if ($urandom_range(0, 7) == 0) begin
          // frame narrower than one block
          w = $urandom_range(1, a - 1);
          h = $urandom_range(1, 2 * a);
        end else begin
          w = a * $urandom_range(1, (a <= 3) ? 4 : 2) + $urandom_range(0, (a <= 4) ? a - 1 : 2);
          h = a * $urandom_range(1, (a <= 3) ? 2 : 1) + $urandom_range(0, (a <= 4) ? a - 1 : 2);
        end
        frames = (a <= 3) ? $urandom_range(1, 2) : 1;
        f = (a == 8 && $urandom_range(0, 1) == 1) ? -int'($urandom_range(9, 16)) : -a;
        n = w * h * frames;
        cut_short = ($urandom_range(0, 5) == 0);
        if (cut_short) n = $urandom_range(1, n);
        mid = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n - 1) : 0;

        realign_frame();
        write_reg(REG_WIDTH, CFG_W'(w));
        write_reg(REG_HEIGHT, CFG_W'(h));
        write_reg(REG_CHANNELS, pad_word($urandom_range(0, 3), CHAN_W));
        write_reg(REG_FACTOR, pad_word(f, FACT_W));
        for (int i = 0; i < n; i++) begin
          // channel mode may flip in the middle of a block
          if (mid != 0 && i == mid) write_reg(REG_CHANNELS, pad_word($urandom_range(0, 3), CHAN_W));
          send_pixel(rand_sample(), rand_sample(), rand_sample());
        end
        if (!cut_short) shrink_blocks += (w / a) * (h / a) * frames;
      end else begin
        // Copy or enlarge, any size including out of range ones
        sel = $urandom_range(0, 9);
        if (sel < 3) f = int'($urandom_range(0, 2)) - 1;
        else if (sel < 7) f = $urandom_range(2, 4);
        else if (sel < 9) f = $urandom_range(5, 8);
        else f = $urandom_range(9, 15);
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(0, 2047);
        h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(0, 2047);
        n = (f > 4) ? $urandom_range(2, 5) : $urandom_range(6, 20);
        mid = ($urandom_range(0, 2) == 0) ? $urandom_range(1, n - 1) : 0;

        write_reg(REG_WIDTH, CFG_W'(w));
        write_reg(REG_HEIGHT, CFG_W'(h));
        write_reg(REG_CHANNELS, pad_word($urandom_range(0, 3), CHAN_W));
        write_reg(REG_FACTOR, pad_word(f, FACT_W));
        for (int i = 0; i < n; i++) begin
          // shrinking the width mid-row makes the position wrap
          if (mid != 0 && i == mid) begin
            write_reg(REG_WIDTH, CFG_W'($urandom_range(0, 3)));
            write_reg(REG_CHANNELS, pad_word($urandom_range(0, 3), CHAN_W));
          end
          send_pixel(rand_sample(), rand_sample(), rand_sample());
        end
      end
    end

    // Wind down and give the verdict
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
